FILE: rtl/block_rms_level_meter_core_defines.svh
// Assertion macros for the block RMS level meter checker.
// Depends on a clock i_clk and an active-low reset i_rst_n in the using scope.
`ifndef BLOCK_RMS_LEVEL_METER_CORE_DEFINES_SVH
`define BLOCK_RMS_LEVEL_METER_CORE_DEFINES_SVH

// Same-cycle implication, switched off while reset is asserted
`define BLM_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("blm: same-cycle check failed");

// Next-cycle implication, switched off while reset is asserted
`define BLM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("blm: next-cycle check failed");

// Next-cycle implication that also watches reset itself
`define BLM_ASSERT_RESET(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("blm: reset check failed");

`endif

FILE: rtl/blm_pkg.sv
// Shared constants and types for the block RMS level meter.
// No dependencies; imported by every module of the block.
package blm_pkg;

    // default parameter values
    localparam int unsigned MAX_BLOCK_DEF   = 1024;
    localparam int unsigned SAMPLE_BITS_DEF = 16;

    // fixed gain applied to every sample
    localparam int unsigned GAIN = 5;

    // register and result field widths
    localparam int unsigned LEN_W    = 11;
    localparam int unsigned ALPHA_W  = 16;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned RMS_W    = 18;
    localparam int unsigned BLKNUM_W = 16;

    // entries between the accumulator and the block-end arithmetic
    localparam int unsigned QUEUE_DEPTH = 2;

    // register reset values
    localparam logic [LEN_W-1:0]   BLOCK_LENGTH_RST = 11'd256;
    localparam logic [ALPHA_W-1:0] SMOOTH_ALPHA_RST = 16'd4588;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_BLOCK_LENGTH = 1'b0,
        CFG_SMOOTH_ALPHA = 1'b1
    } t_cfg_idx;

    // queue status seen by both sides
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

FILE: rtl/blm_front.sv
// Front end: takes samples, applies gain, squares and accumulates per block.
// Uses blm_pkg; hands finished block sums to blm_queue.
module blm_front #(
    parameter int unsigned MAX_BLOCK   = blm_pkg::MAX_BLOCK_DEF,
    parameter int unsigned SAMPLE_BITS = blm_pkg::SAMPLE_BITS_DEF,
    parameter int unsigned CNT_W       = $clog2(MAX_BLOCK + 1),
    parameter int unsigned SUM_W       = 2 * (SAMPLE_BITS + 2) + CNT_W
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0]  i_sample,
    input  logic [blm_pkg::LEN_W-1:0]      i_block_length,
    input  blm_pkg::t_q_stat               i_q_stat,
    output logic                           o_push,
    output logic [SUM_W-1:0]               o_push_sum,
    output logic [CNT_W-1:0]               o_push_cnt
);
    import blm_pkg::*;

    localparam int unsigned MAG_W = SAMPLE_BITS + 2;
    localparam int unsigned SQ_W  = 2 * MAG_W;
    localparam int unsigned CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    logic [SUM_W-1:0]       r_sum;
    logic [CNT_W-1:0]       r_cnt;
    logic [SAMPLE_BITS-1:0] w_abs;
    logic [MAG_W-1:0]       w_mag;
    logic [SQ_W-1:0]        w_sq;
    logic [SUM_W-1:0]       w_sum_nx;
    logic [CMP_W-1:0]       w_len;
    logic [CMP_W-1:0]       w_eff;
    logic [CMP_W-1:0]       w_cnt_inc;
    logic                   w_end;
    logic                   w_accept;

    // magnitude times five, then squared
    assign w_abs    = i_sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-i_sample)
                                              : SAMPLE_BITS'(i_sample);
    assign w_mag    = {2'b00, w_abs} + {w_abs, 2'b00};
    assign w_sq     = SQ_W'(w_mag) * SQ_W'(w_mag);
    assign w_sum_nx = r_sum + SUM_W'(w_sq);

    // effective block length: zero counts as one, clamp at the maximum
    always_comb begin
        w_len = CMP_W'(i_block_length);
        if (w_len == '0) begin
            w_eff = CMP_W'(1);
        end else if (w_len > CMP_W'(MAX_BLOCK)) begin
            w_eff = CMP_W'(MAX_BLOCK);
        end else begin
            w_eff = w_len;
        end
    end

    assign w_cnt_inc = CMP_W'(r_cnt) + CMP_W'(1);
    assign w_end     = (w_cnt_inc >= w_eff);

    // only a block-ending sample needs room in the queue
    assign o_in_stall = i_q_stat.full && w_end;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign o_push     = w_accept && w_end;
    assign o_push_sum = w_sum_nx;
    assign o_push_cnt = CNT_W'(w_cnt_inc);

    // accumulator and sample count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else if (w_accept) begin
            if (w_end) begin
                r_sum <= '0;
                r_cnt <= '0;
            end else begin
                r_sum <= w_sum_nx;
                r_cnt <= CNT_W'(w_cnt_inc);
            end
        end
    end

endmodule

FILE: rtl/blm_queue.sv
// Short FIFO of finished block sums between front and back end.
// Uses blm_pkg for depth and the status struct.
module blm_queue #(
    parameter int unsigned DW = 58
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [DW-1:0]    i_push_data,
    input  logic             i_pop,
    output logic [DW-1:0]    o_head,
    output blm_pkg::t_q_stat o_stat
);
    import blm_pkg::*;

    localparam int unsigned PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);

    logic [DW-1:0]     r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [FILL_W-1:0] r_fill;
    logic              w_do_push;
    logic              w_do_pop;

    assign o_stat.empty = (r_fill == '0);
    assign o_stat.full  = (r_fill == FILL_W'(QUEUE_DEPTH));
    assign o_head       = r_mem[r_rd_ptr];

    assign w_do_push = i_push && !o_stat.full;
    assign w_do_pop  = i_pop && !o_stat.empty;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : r_rd_ptr + 1'b1;
            end
            case ({w_do_push, w_do_pop})
                2'b10:   r_fill <= r_fill + 1'b1;
                2'b01:   r_fill <= r_fill - 1'b1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

FILE: rtl/blm_back.sv
// Back end: divides a block sum by its count, takes the square root,
// updates the smoothed level and drives the result register. Uses blm_pkg.
module blm_back #(
    parameter int unsigned MAX_BLOCK   = blm_pkg::MAX_BLOCK_DEF,
    parameter int unsigned SAMPLE_BITS = blm_pkg::SAMPLE_BITS_DEF,
    parameter int unsigned CNT_W       = $clog2(MAX_BLOCK + 1),
    parameter int unsigned SUM_W       = 2 * (SAMPLE_BITS + 2) + CNT_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  blm_pkg::t_q_stat              i_q_stat,
    input  logic [SUM_W-1:0]              i_head_sum,
    input  logic [CNT_W-1:0]              i_head_cnt,
    output logic                          o_pop,
    input  logic [blm_pkg::ALPHA_W-1:0]   i_smooth_alpha,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [blm_pkg::RMS_W-1:0]     o_block_rms,
    output logic [blm_pkg::RMS_W-1:0]     o_smoothed_level,
    output logic [blm_pkg::BLKNUM_W-1:0]  o_block_number
);
    import blm_pkg::*;

    localparam int unsigned MAG_W  = SAMPLE_BITS + 2;
    localparam int unsigned RT_W   = (SUM_W + 1) / 2;
    localparam int unsigned RAD_W  = 2 * RT_W;
    localparam int unsigned SR_W   = RT_W + 2;
    localparam int unsigned LVL_W  = MAG_W + ALPHA_W;
    localparam int unsigned PA_W   = LVL_W + ALPHA_W + 1;
    localparam int unsigned PB_W   = ALPHA_W + MAG_W;
    localparam int unsigned ACC_W  = PA_W + 1;
    localparam int unsigned LSH_W  = ACC_W - ALPHA_W;
    localparam int unsigned STEP_W = $clog2(SUM_W + 1);

    localparam logic [MAG_W-1:0]   LEVEL_MAX     = MAG_W'(GAIN) << (SAMPLE_BITS - 1);
    localparam logic [LVL_W-1:0]   LEVEL_REG_MAX = {LEVEL_MAX, {ALPHA_W{1'b0}}};
    localparam logic [ALPHA_W:0]   ALPHA_ONE     = (ALPHA_W + 1)'(1) << ALPHA_W;
    localparam logic [ACC_W-1:0]   ROUND_HALF    = ACC_W'(1) << (ALPHA_W - 1);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_DIV  = 7'b0000010,
        ST_SQRT = 7'b0000100,
        ST_MULA = 7'b0001000,
        ST_MULB = 7'b0010000,
        ST_ACC  = 7'b0100000,
        ST_PUSH = 7'b1000000
    } t_back_state;

    t_back_state           r_state;
    logic [RAD_W-1:0]      r_work;
    logic [CNT_W-1:0]      r_div;
    logic [CNT_W-1:0]      r_drem;
    logic [SR_W-1:0]       r_srem;
    logic [RT_W-1:0]       r_root;
    logic [STEP_W-1:0]     r_step;
    logic [MAG_W-1:0]      r_rms;
    logic [PA_W-1:0]       r_prod_a;
    logic [PB_W-1:0]       r_prod_b;
    logic [LVL_W-1:0]      r_level;
    logic [BLKNUM_W-1:0]   r_blk;
    logic                  r_out_valid;
    logic [RMS_W-1:0]      r_out_rms;
    logic [RMS_W-1:0]      r_out_lvl;
    logic [BLKNUM_W-1:0]   r_out_blk;

    logic [CNT_W:0]        w_dtrial;
    logic                  w_dge;
    logic [CNT_W:0]        w_ddiff;
    logic [SR_W+1:0]       w_sbring;
    logic [SR_W+1:0]       w_strial;
    logic                  w_sge;
    logic [RT_W-1:0]       w_root_nx;
    logic [MAG_W-1:0]      w_rms_sat;
    logic [ALPHA_W:0]      w_one_minus;
    logic [ACC_W-1:0]      w_acc;
    logic [LSH_W-1:0]      w_lvl_sh;
    logic [LVL_W-1:0]      w_lvl_sat;
    logic [MAG_W-1:0]      w_lvl_top;
    logic [MAG_W-1:0]      w_lvl_out;
    logic                  w_out_free;

    // restoring divider, one quotient bit a cycle, quotient shifts into r_work
    assign w_dtrial = {r_drem, r_work[SUM_W-1]};
    assign w_dge    = (w_dtrial >= {1'b0, r_div});
    assign w_ddiff  = w_dtrial - {1'b0, r_div};

    // digit-by-digit square root, two radicand bits a cycle
    assign w_sbring  = {r_srem, r_work[RAD_W-1:RAD_W-2]};
    assign w_strial  = (SR_W + 2)'({r_root, 2'b01});
    assign w_sge     = (w_sbring >= w_strial);
    assign w_root_nx = {r_root[RT_W-2:0], w_sge};
    assign w_rms_sat = (w_root_nx > RT_W'(LEVEL_MAX)) ? LEVEL_MAX : MAG_W'(w_root_nx);

    // one-pole smoother with rounding and saturation
    assign w_one_minus = ALPHA_ONE - {1'b0, i_smooth_alpha};
    assign w_acc       = ACC_W'(r_prod_a) + ACC_W'({r_prod_b, {ALPHA_W{1'b0}}}) + ROUND_HALF;
    assign w_lvl_sh    = w_acc[ACC_W-1:ALPHA_W];
    assign w_lvl_sat   = (w_lvl_sh > LSH_W'(LEVEL_REG_MAX)) ? LEVEL_REG_MAX
                                                             : LVL_W'(w_lvl_sh);

    // reported level: integer part of the smoother state
    assign w_lvl_top = r_level[LVL_W-1:ALPHA_W];
    assign w_lvl_out = (w_lvl_top > LEVEL_MAX) ? LEVEL_MAX : w_lvl_top;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_pop      = (r_state == ST_IDLE) && !i_q_stat.empty;

    // sequencer and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_level <= '0;
            r_blk   <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_q_stat.empty) begin
                        r_work  <= RAD_W'(i_head_sum);
                        r_div   <= i_head_cnt;
                        r_drem  <= '0;
                        r_step  <= '0;
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_drem <= w_dge ? CNT_W'(w_ddiff) : CNT_W'(w_dtrial);
                    r_work <= RAD_W'({r_work[SUM_W-2:0], w_dge});
                    if (r_step == STEP_W'(SUM_W - 1)) begin
                        r_step  <= '0;
                        r_srem  <= '0;
                        r_root  <= '0;
                        r_state <= ST_SQRT;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                ST_SQRT: begin
                    r_srem <= w_sge ? SR_W'(w_sbring - w_strial) : SR_W'(w_sbring);
                    r_root <= w_root_nx;
                    r_work <= r_work << 2;
                    if (r_step == STEP_W'(RT_W - 1)) begin
                        r_step  <= '0;
                        r_rms   <= w_rms_sat;
                        r_state <= ST_MULA;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                ST_MULA: begin
                    r_prod_a <= PA_W'(r_level) * PA_W'(w_one_minus);
                    r_state  <= ST_MULB;
                end
                ST_MULB: begin
                    r_prod_b <= PB_W'(i_smooth_alpha) * PB_W'(r_rms);
                    r_state  <= ST_ACC;
                end
                ST_ACC: begin
                    r_level <= w_lvl_sat;
                    r_state <= ST_PUSH;
                end
                ST_PUSH: begin
                    if (w_out_free) begin
                        r_blk   <= r_blk + 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // result register: loads when empty or when the held result is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_PUSH && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_PUSH && w_out_free) begin
            r_out_rms <= RMS_W'(r_rms);
            r_out_lvl <= RMS_W'(w_lvl_out);
            r_out_blk <= r_blk + 1'b1;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_block_rms      = r_out_rms;
    assign o_smoothed_level = r_out_lvl;
    assign o_block_number   = r_out_blk;

endmodule

FILE: rtl/block_rms_level_meter_core.sv
// Top level of the block RMS level meter: configuration registers and the
// front end, block queue and back end. Uses blm_pkg, blm_front, blm_queue, blm_back.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+-------------------------------------
//  sample   | in        | i_in_valid / o_in_stall   | i_sample
//  result   | out       | o_out_valid / i_out_stall | o_block_rms, o_smoothed_level,
//           |           |                           | o_block_number
//  config   | in        | i_cfg_we                  | i_cfg_idx, i_cfg_wdata
//
// A sample is accumulated in the front end as it is accepted; a block-ending sample
// stalls only when both queue entries are taken.
// The back end takes one block at a time from the queue and runs it through
// the one-bit-a-cycle divider followed by the one-bit-a-cycle square root.
// Reset is synchronous; there is no clearing pass.
// A stalled result holds in the output register while the back end works on.
module block_rms_level_meter_core #(
    parameter int unsigned MAX_BLOCK   = blm_pkg::MAX_BLOCK_DEF,
    parameter int unsigned SAMPLE_BITS = blm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [blm_pkg::RMS_W-1:0]     o_block_rms,
    output logic [blm_pkg::RMS_W-1:0]     o_smoothed_level,
    output logic [blm_pkg::BLKNUM_W-1:0]  o_block_number,
    input  logic                          i_cfg_we,
    input  blm_pkg::t_cfg_idx             i_cfg_idx,
    input  logic [blm_pkg::CFG_W-1:0]     i_cfg_wdata
);
    import blm_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_BLOCK + 1);
    localparam int unsigned SUM_W = 2 * (SAMPLE_BITS + 2) + CNT_W;
    localparam int unsigned QD_W  = SUM_W + CNT_W;

    logic [LEN_W-1:0]   r_block_length;
    logic [ALPHA_W-1:0] r_smooth_alpha;
    t_q_stat            w_q_stat;
    logic               w_push;
    logic [SUM_W-1:0]   w_push_sum;
    logic [CNT_W-1:0]   w_push_cnt;
    logic               w_pop;
    logic [QD_W-1:0]    w_head;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_length <= BLOCK_LENGTH_RST;
            r_smooth_alpha <= SMOOTH_ALPHA_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BLOCK_LENGTH: r_block_length <= i_cfg_wdata[LEN_W-1:0];
                CFG_SMOOTH_ALPHA: r_smooth_alpha <= i_cfg_wdata[ALPHA_W-1:0];
                default:          r_block_length <= r_block_length;
            endcase
        end
    end

    // sample intake and accumulation
    blm_front #(
        .MAX_BLOCK   (MAX_BLOCK),
        .SAMPLE_BITS (SAMPLE_BITS),
        .CNT_W       (CNT_W),
        .SUM_W       (SUM_W)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample       (i_sample),
        .i_block_length (r_block_length),
        .i_q_stat       (w_q_stat),
        .o_push         (w_push),
        .o_push_sum     (w_push_sum),
        .o_push_cnt     (w_push_cnt)
    );

    // finished blocks waiting for the back end
    blm_queue #(
        .DW (QD_W)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data ({w_push_sum, w_push_cnt}),
        .i_pop       (w_pop),
        .o_head      (w_head),
        .o_stat      (w_q_stat)
    );

    // mean, root, smoothing and result
    blm_back #(
        .MAX_BLOCK   (MAX_BLOCK),
        .SAMPLE_BITS (SAMPLE_BITS),
        .CNT_W       (CNT_W),
        .SUM_W       (SUM_W)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_stat         (w_q_stat),
        .i_head_sum       (w_head[QD_W-1:CNT_W]),
        .i_head_cnt       (w_head[CNT_W-1:0]),
        .o_pop            (w_pop),
        .i_smooth_alpha   (r_smooth_alpha),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_block_rms      (o_block_rms),
        .o_smoothed_level (o_smoothed_level),
        .o_block_number   (o_block_number)
    );

endmodule

FILE: rtl/blm_checker.sv
// Port-level checks on the block RMS level meter result channel.
// Uses blm_pkg and the assertion macros; bound to block_rms_level_meter_core.
`include "block_rms_level_meter_core_defines.svh"

module blm_checker #(
    parameter int unsigned SAMPLE_BITS = blm_pkg::SAMPLE_BITS_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [blm_pkg::RMS_W-1:0]     o_block_rms,
    input logic [blm_pkg::RMS_W-1:0]     o_smoothed_level,
    input logic [blm_pkg::BLKNUM_W-1:0]  o_block_number
);
    import blm_pkg::*;

    localparam longint unsigned LEVEL_MAX = longint'(GAIN) << (SAMPLE_BITS - 1);
    localparam longint unsigned RMS_ONES  = (longint'(1) << RMS_W) - 1;
    localparam logic [RMS_W-1:0] BOUND    = (LEVEL_MAX > RMS_ONES) ? '1 : RMS_W'(LEVEL_MAX);

    // a held result stays offered
    `BLM_ASSERT_NEXT(a_valid_holds, o_out_valid && i_out_stall, o_out_valid)

    // RMS and level never go past full scale
    `BLM_ASSERT_SAME(a_rms_bound, o_out_valid, o_block_rms <= BOUND)
    `BLM_ASSERT_SAME(a_level_bound, o_out_valid, o_smoothed_level <= BOUND)

    // a result straight after a taken one carries the next block number
    `BLM_ASSERT_NEXT(a_blk_step, o_out_valid && !i_out_stall,
        !o_out_valid || o_block_number == BLKNUM_W'($past(o_block_number) + 1'b1))

    // reset empties the result register
    `BLM_ASSERT_RESET(a_rst_clears, !i_rst_n, !o_out_valid)

endmodule

bind block_rms_level_meter_core blm_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_blm_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_block_rms      (o_block_rms),
    .o_smoothed_level (o_smoothed_level),
    .o_block_number   (o_block_number)
);
